// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer task scheduler package
// Shared operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int unsigned HandleW = 4;
    localparam int unsigned LockW   = 7;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_POLL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_SPARE   = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_TEST  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_SHWR  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/software_timer_task_scheduler_unit.sv =====
// Steps: unlock goes straight to the result; add multiplies, then writes; remove and poll read
// and test entries in turn; a dropped task has each later entry moved down to close the gap.
// Throughput: one word at a time; the block is not ready until the result is taken.
// The entry table is one memory with a single registered read port, which sets the scan rate.
// Synchronous active-low reset clears the entry count, handle map and held locks;
// table contents are left as they are.
// ----------------------------------------------------------------------------
// Timer task scheduler
// Insertion-ordered table of timed tasks, scanned one entry at a time.
// ----------------------------------------------------------------------------
module software_timer_task_scheduler_unit
    import sts_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], now[33:2], callback_id[41:34], delay_count[73:42],
    // unit_ticks[89:74], lock_mask[96:90], repeatable[97], handle[101:98]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], handle_out[5:2], dispatched[6], callback_out[14:7]
    output logic [15:0]  m_axis_tdata
);

    localparam int unsigned Cap  = (MAX_TASKS < 16) ? MAX_TASKS : 16;
    localparam int unsigned IdxW = $clog2(Cap);
    localparam int unsigned CntW = $clog2(Cap + 1);
    localparam int unsigned EntW = HandleW + 8 + 32 + 32 + LockW + 1;

    // Entry record: handle, callback, start, delay, lock, repeat
    typedef struct packed {
        logic [HandleW-1:0] hnd;
        logic [7:0]         cb;
        logic [31:0]        start;
        logic [31:0]        dly;
        logic [LockW-1:0]   lock;
        logic               rep;
    } t_entry;

    t_entry r_mem [Cap];
    t_entry r_rd;

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_count, n_count;
    logic [15:0]         r_busy, n_busy;
    logic [LockW-1:0]    r_held, n_held;
    logic [CntW-1:0]     r_idx, n_idx;
    t_op                 r_op, n_op;
    logic [31:0]         r_now, n_now;
    logic [7:0]          r_cbin, n_cbin;
    logic [31:0]         r_dc, n_dc;
    logic [15:0]         r_du, n_du;
    logic [LockW-1:0]    r_lockin, n_lockin;
    logic                r_repin, n_repin;
    logic [HandleW-1:0]  r_hin, n_hin;
    logic [31:0]         r_prod, n_prod;
    logic [15:0]         r_res, n_res;
    logic                r_vld, n_vld;

    // Memory write and read controls
    logic                we;
    logic [IdxW-1:0]     waddr, raddr;
    t_entry              wdata;
    logic [HandleW-1:0]  free_h;
    logic                free_ok;
    logic [31:0]         elapsed;

    // Lowest free handle
    always_comb begin
        free_h  = '0;
        free_ok = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_h  = HandleW'(i);
                free_ok = 1'b1;
            end
        end
    end

    // The read address follows the next index, so r_rd holds the entry at r_idx.
    assign elapsed = r_now - r_rd.start;
    assign raddr   = n_idx[IdxW-1:0];

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    // Sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_busy = r_busy; n_held = r_held;
        n_idx = r_idx; n_op = r_op; n_now = r_now; n_cbin = r_cbin; n_dc = r_dc;
        n_du = r_du; n_lockin = r_lockin; n_repin = r_repin; n_hin = r_hin;
        n_prod = r_prod; n_res = r_res; n_vld = r_vld;
        we = 1'b0; waddr = r_idx[IdxW-1:0]; wdata = r_rd;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op = t_op'(s_axis_tdata[1:0]);
                    n_now = s_axis_tdata[33:2];
                    n_cbin = s_axis_tdata[41:34];
                    n_dc = s_axis_tdata[73:42];
                    n_du = s_axis_tdata[89:74];
                    n_lockin = s_axis_tdata[96:90];
                    n_repin = s_axis_tdata[97];
                    n_hin = s_axis_tdata[101:98];
                    n_idx = '0;
                    n_res = '0;
                    case (t_op'(s_axis_tdata[1:0]))
                        OP_ADD: n_state = S_MUL;
                        OP_UNLOCK: begin
                            n_held = r_held & ~s_axis_tdata[96:90];
                            n_state = S_OUT;
                        end
                        default: begin
                            n_res[1:0] = ST_MISSING;
                            n_state = (r_count == '0) ? S_OUT : S_READ;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_prod = r_dc * {16'd0, r_du};
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_count >= CntW'(Cap) || !free_ok) begin
                    n_res[1:0] = ST_FULL;
                end else begin
                    we = 1'b1;
                    waddr = r_count[IdxW-1:0];
                    wdata = '{hnd: free_h, cb: r_cbin, start: r_now, dly: r_prod,
                              lock: r_lockin, rep: r_repin};
                    n_busy = r_busy | (16'd1 << free_h);
                    n_count = r_count + 1'b1;
                    n_res[5:2] = free_h;
                end
                n_state = S_OUT;
            end
            S_READ: n_state = S_TEST;
            S_TEST: begin
                if (r_op == OP_REMOVE && r_rd.hnd == r_hin) begin
                    n_res[1:0] = ST_DONE;
                    n_busy = r_busy & ~(16'd1 << r_rd.hnd);
                    n_state = S_SHIFT;
                end else if (r_op == OP_POLL && elapsed >= r_rd.dly
                             && (r_held & r_rd.lock) == '0) begin
                    n_res = {1'b0, r_rd.cb, 1'b1, 4'd0, ST_DONE};
                    n_held = r_held | r_rd.lock;
                    if (r_rd.rep) begin
                        we = 1'b1;
                        wdata = r_rd;
                        wdata.start = r_now;
                        n_state = S_OUT;
                    end else begin
                        n_busy = r_busy & ~(16'd1 << r_rd.hnd);
                        n_state = S_SHIFT;
                    end
                end else if (r_idx + 1'b1 >= r_count) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_SHIFT: begin
                // Close the gap: read the next slot, then write it one place down
                if (r_idx + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                we = 1'b1;
                waddr = IdxW'(r_idx - 1'b1);
                wdata = r_rd;
                n_state = S_SHIFT;
            end
            S_OUT: begin
                n_vld = 1'b1;
                if (r_vld && m_axis_tready) begin
                    n_vld = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_busy <= '0; r_held <= '0;
            r_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_busy <= n_busy;
            r_held <= n_held; r_vld <= n_vld;
        end
        r_idx <= n_idx; r_op <= n_op; r_now <= n_now; r_cbin <= n_cbin; r_dc <= n_dc;
        r_du <= n_du; r_lockin <= n_lockin; r_repin <= n_repin; r_hin <= n_hin;
        r_prod <= n_prod; r_res <= n_res;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_res;

endmodule

// ===== sim/software_timer_task_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer task scheduler testbench
// Drives add, remove, unlock and poll words into the scheduler, predicts every
// answer with a behavioural copy of the task table and compares field by field.
// ----------------------------------------------------------------------------
module software_timer_task_scheduler_unit_tb
    import sts_pkg::*;
();

    localparam int unsigned TableCap = 16;

    typedef struct packed {
        logic [3:0]  handle;
        logic        repeatable;
        logic [6:0]  lock_mask;
        logic [15:0] unit_ticks;
        logic [31:0] delay_count;
        logic [7:0]  callback_id;
        logic [31:0] now;
        t_op         op;
    } t_cmd;

    typedef struct packed {
        logic [7:0] callback_out;
        logic       dispatched;
        logic [3:0] handle_out;
        t_status    status;
    } t_answer;

    typedef struct {
        logic [3:0]  hnd;
        logic [7:0]  cb;
        logic [31:0] start;
        logic [31:0] dly;
        logic [6:0]  lock;
        logic        rpt;
    } t_task;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // operation, now, callback_id, delay_count, unit_ticks, lock_mask, repeatable, handle
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, handle_out, dispatched, callback_out
    logic [15:0]  m_axis_tdata;

    software_timer_task_scheduler_unit #(.MAX_TASKS(TableCap)) u_dut (.*);

    // Predicted scheduler state.
    t_task       tasks[$];
    logic [15:0] busy_handles;
    logic [6:0]  held;
    t_answer     pending_answers[$];
    int          errors;
    bit          quiet_sink;
    bit          hold_sink;
    logic [31:0] tick;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    initial begin
        #200ms;
        $display("[software_timer_task_scheduler_unit] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Work out the answer to one word and update the predicted table.
    function automatic t_answer schedule_step(input t_cmd c);
        t_answer a;
        int      h;
        a = '{callback_out: 8'd0, dispatched: 1'b0, handle_out: 4'd0, status: ST_DONE};
        case (c.op)
            OP_ADD: begin
                h = -1;
                for (int i = 15; i >= 0; i--) if (!busy_handles[i]) h = i;
                if (tasks.size() >= TableCap || h < 0) begin
                    a.status = ST_FULL;
                end else begin
                    tasks.push_back('{hnd: h[3:0], cb: c.callback_id, start: c.now,
                        dly: c.delay_count * {16'd0, c.unit_ticks},
                        lock: c.lock_mask, rpt: c.repeatable});
                    busy_handles[h] = 1'b1;
                    a.handle_out = h[3:0];
                end
            end
            OP_REMOVE: begin
                a.status = ST_MISSING;
                foreach (tasks[i]) if (tasks[i].hnd == c.handle) begin
                    busy_handles[c.handle] = 1'b0;
                    tasks.delete(i);
                    a.status = ST_DONE;
                    break;
                end
            end
            OP_UNLOCK: held = held & ~c.lock_mask;
            default: begin
                a.status = ST_MISSING;
                foreach (tasks[i]) begin
                    if (c.now - tasks[i].start >= tasks[i].dly &&
                        (held & tasks[i].lock) == 7'd0) begin
                        held |= tasks[i].lock;
                        a.callback_out = tasks[i].cb;
                        a.dispatched = 1'b1;
                        a.status = ST_DONE;
                        if (tasks[i].rpt) begin
                            tasks[i].start = c.now;
                        end else begin
                            busy_handles[tasks[i].hnd] = 1'b0;
                            tasks.delete(i);
                        end
                        break;
                    end
                end
            end
        endcase
        return a;
    endfunction

    // Result side: random stalls, one long hold-off, checks against the oldest expectation.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            if (!quiet_sink && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_answer got, want;
            got = m_axis_tdata[14:0];
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.handle_out !== want.handle_out)
                    report_mismatch("handle_out", got.handle_out, want.handle_out);
                if (got.dispatched !== want.dispatched)
                    report_mismatch("dispatched", got.dispatched, want.dispatched);
                if (got.callback_out !== want.callback_out)
                    report_mismatch("callback_out", got.callback_out, want.callback_out);
            end
        end
    end

    // Offer one word and hold it until accepted; the expectation is queued at acceptance.
    task automatic send_word(input t_cmd c, input bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_answers.push_back(schedule_step(c));
        @(negedge i_clk);
    endtask

    function automatic t_cmd make_cmd(input t_op op, input logic [31:0] now,
                                      input logic [7:0] cb, input logic [31:0] cnt,
                                      input logic [15:0] unit, input logic [6:0] lk,
                                      input logic rp, input logic [3:0] h);
        return '{handle: h, repeatable: rp, lock_mask: lk, unit_ticks: unit,
                 delay_count: cnt, callback_id: cb, now: now, op: op};
    endfunction

    // Mostly a running clock with adds, polls and removes of live handles.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   k;
        c = make_cmd(t_op'($urandom_range(0, 3)), 32'd0, 8'($urandom), 32'd0, 16'd0,
                     7'($urandom), 1'($urandom), 4'($urandom));
        tick += $urandom_range(0, 40);
        c.now = ($urandom_range(0, 19) == 0) ? $urandom : tick;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            c.delay_count = $urandom_range(0, 8);
            c.unit_ticks  = 16'($urandom_range(0, 30));
        end else begin
            c.delay_count = $urandom;
            c.unit_ticks  = 16'($urandom);
        end
        if ($urandom_range(0, 2) != 0) c.lock_mask &= 7'($urandom);
        if (c.op == OP_REMOVE && tasks.size() != 0 && $urandom_range(0, 3) != 0)
            c.handle = tasks[$urandom_range(0, tasks.size() - 1)].hnd;
        return c;
    endfunction

    // Directed rows; a known answer is checked in place where it is obvious.
    typedef struct {
        t_cmd    cmd;
        bit      has_answer;
        t_answer answer;
    } t_row;

    initial begin
        t_row    rows[$];
        t_answer none;
        t_cmd    c;
        none = '{callback_out: 8'd0, dispatched: 1'b0, handle_out: 4'd0, status: ST_MISSING};
        errors = 0; busy_handles = '0; held = '0; tick = 32'd1000;
        quiet_sink = 1'b0; hold_sink = 1'b0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table: poll and remove miss, unlock is done.
        rows.push_back('{make_cmd(OP_POLL, 32'd0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 4'hF), 1, none});
        rows.push_back('{make_cmd(OP_UNLOCK, 0, 0, 0, 0, 7'h7F, 0, 0), 1,
                         '{8'd0, 1'b0, 4'd0, ST_DONE}});
        // Zero delay with callback zero, then extremes of every field.
        rows.push_back('{make_cmd(OP_ADD, 32'd5, 8'd0, 0, 0, 7'h01, 0, 0), 1,
                         '{8'd0, 1'b0, 4'd0, ST_DONE}});
        rows.push_back('{make_cmd(OP_POLL, 32'd5, 0, 0, 0, 0, 0, 0), 1,
                         '{8'd0, 1'b1, 4'd0, ST_DONE}});
        rows.push_back('{make_cmd(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                         7'h7F, 1, 4'hF), 0, none});
        rows.push_back('{make_cmd(OP_ADD, 32'hFFFF_FFF0, 8'h12, 32'd4, 16'd8, 7'h02, 1, 0),
                         0, none});
        rows.push_back('{make_cmd(OP_POLL, 32'd16, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_cmd(OP_POLL, 32'd17, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_cmd(OP_UNLOCK, 0, 0, 0, 0, 7'h7F, 0, 0), 0, none});
        rows.push_back('{make_cmd(OP_POLL, 32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 4'd0), 0, none});
        rows.push_back('{make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 4'd9), 1, none});
        foreach (rows[i]) begin
            send_word(rows[i].cmd, 1'b0);
            if (rows[i].has_answer) begin
                void'(pending_answers.pop_back());
                pending_answers.push_back(rows[i].answer);
            end
        end
        // Fill beyond the table to reach the full answer, then empty it again.
        for (int i = 0; i < 18; i++)
            send_word(make_cmd(OP_ADD, tick, 8'(i), 32'd100, 16'd1, 7'd0, 0, 0), 1'b1);
        for (int i = 0; i < 16; i++)
            send_word(make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 4'(i)), 1'b1);
        send_word(make_cmd(OP_UNLOCK, 0, 0, 0, 0, 7'h7F, 0, 0), 1'b0);

        // Random traffic with a long receiver hold-off and a drain pause.
        for (int n = 0; n < 750; n++) begin
            if (n == 200) hold_sink = 1'b1;
            if (n == 400) begin
                s_axis_tvalid <= 1'b0;
                while (pending_answers.size() != 0) @(negedge i_clk);
            end
            if (n == 650) quiet_sink = 1'b1;
            c = random_cmd();
            if (c.op == OP_UNLOCK && $urandom_range(0, 1) == 0) c.lock_mask = 7'h7F;
            send_word(c, n < 650);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("[software_timer_task_scheduler_unit] OK");
        end else begin
            $display("[software_timer_task_scheduler_unit] ERROR");
        end
        $finish;
    end

endmodule
